/* rtl/core/mrda_pkg.sv */
// Shared types and constants for the masked result drain arbiter.
// Used by every module of the block; depends on nothing else.
package mrda_pkg;

    // fixed field widths of the stream items
    localparam int DATA_W     = 32;
    localparam int NUM_LANES  = 4;
    localparam int SRC_W      = 2;
    localparam int TURN_CNT_W = 4;
    localparam int RETIRE_W   = 3;
    localparam int IN_TDATA_W = 2 * NUM_LANES * DATA_W;
    localparam int OUT_PAD_W  = 5;
    localparam int OUT_TDATA_W = DATA_W + NUM_LANES * DATA_W + SRC_W + 1 + OUT_PAD_W;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int PART_W     = 16;

    localparam logic [1:0] REG_ZERO_VALUE = 2'd0;
    localparam logic [1:0] REG_MASK_MODE  = 2'd1;
    localparam logic [1:0] REG_PARTITION  = 2'd2;

    // source numbers
    localparam logic [SRC_W-1:0] SRC_A = 2'd0;
    localparam logic [SRC_W-1:0] SRC_B = 2'd1;
    localparam logic [SRC_W-1:0] SRC_C = 2'd2;

    typedef enum logic [1:0] {
        MARKER_DATA  = 2'd0,
        MARKER_START = 2'd1,
        MARKER_END   = 2'd2,
        MARKER_EOS   = 2'd3
    } t_marker;

    typedef enum logic [1:0] {
        MASK_NONE    = 2'd0,
        MASK_NONZERO = 2'd1,
        MASK_ZERO    = 2'd2,
        MASK_INVALID = 2'd3
    } t_mask_mode;

    // scheduler status handed to the merge stage
    typedef struct packed {
        logic             write_valid;
        logic [SRC_W-1:0] next_source;
        logic             all_finished;
        logic             all_done;
    } t_sched_status;

    // one result item
    typedef struct packed {
        logic                              all_finished;
        logic [SRC_W-1:0]                  next_source;
        logic [NUM_LANES-1:0][DATA_W-1:0]  lanes;
        logic [DATA_W-1:0]                 address;
        logic                              write_valid;
    } t_result;

endpackage

/* rtl/core/mrda_lane.sv */
// One masking lane: keeps or replaces a packet value according to the mask mode.
// Depends on mrda_pkg.
module mrda_lane
    import mrda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_mask,
    input  logic [DATA_W-1:0] i_zero,
    input  t_mask_mode        i_mode,
    output logic [DATA_W-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] mask;
    logic [VALUE_WIDTH-1:0] zero;
    logic                   keep;

    assign value = i_value[VALUE_WIDTH-1:0];
    assign mask  = i_mask[VALUE_WIDTH-1:0];
    assign zero  = i_zero[VALUE_WIDTH-1:0];

    // keep decision per mode
    always_comb begin
        unique case (i_mode)
            MASK_NONE:    keep = 1'b1;
            MASK_NONZERO: keep = (mask != zero);
            MASK_ZERO:    keep = (mask == zero);
            MASK_INVALID: keep = 1'b0;
            default:      keep = 1'b0;
        endcase
    end

    assign o_value = DATA_W'(keep ? value : zero);

endmodule

/* rtl/core/mrda_offset.sv */
// Partition base offset: (partition * OUTPUT_BLOCK_ROWS mod 2^32) / PACKED_LANES.
// Product taken in the write's setup cycle, quotient in its access cycle. Depends on mrda_pkg.
module mrda_offset
    import mrda_pkg::*;
#(
    parameter int PACKED_LANES      = 4,
    parameter int OUTPUT_BLOCK_ROWS = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_setup,
    input  logic [PART_W-1:0] i_part,
    input  logic              i_commit,
    output logic [DATA_W-1:0] o_offset
);

    localparam logic [DATA_W:0]   ROWS_C  = (DATA_W + 1)'(OUTPUT_BLOCK_ROWS);
    localparam logic [2*DATA_W-1:0] RECIP3 = (2 * DATA_W)'(64'h0000_0000_AAAA_AAAB);
    localparam int SHIFT = $clog2(PACKED_LANES);

    logic [DATA_W:0]   prod_full;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] r_offset;

    assign prod_full = (DATA_W + 1)'(i_part) * ROWS_C;

    // product captured while the write is in its setup cycle
    always_ff @(posedge i_clk) begin
        if (i_setup) begin
            r_prod <= prod_full[DATA_W-1:0];
        end
    end

    // divide by the pack size: shift, or reciprocal multiply for three
    generate
        if (PACKED_LANES == 3) begin : g_div3
            logic [2*DATA_W-1:0] recip_prod;
            assign recip_prod = (2 * DATA_W)'(r_prod) * RECIP3;
            assign quot = {1'b0, recip_prod[2*DATA_W-1:DATA_W+1]};
        end else begin : g_shift
            assign quot = r_prod >> SHIFT;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_commit) begin
            r_offset <= quot;
        end
    end

    assign o_offset = r_offset;

endmodule

/* rtl/core/mrda_sched.sv */
// Round-robin turn scheduler: current source, turn count, retired sources, write count.
// Depends on mrda_pkg.
module mrda_sched
    import mrda_pkg::*;
#(
    parameter int TURN_LENGTH_A = 4,
    parameter int TURN_LENGTH_B = 6,
    parameter int TURN_LENGTH_C = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_marker           i_marker,
    output t_sched_status     o_status,
    output logic [DATA_W-1:0] o_wr_cnt
);

    logic [SRC_W-1:0]      r_cur_src;
    logic [TURN_CNT_W-1:0] r_turn_cnt;
    logic [RETIRE_W-1:0]   r_retired;
    logic [DATA_W-1:0]     r_wr_cnt;

    logic [SRC_W-1:0]      n_cur_src;
    logic [TURN_CNT_W-1:0] n_turn_cnt;
    logic [RETIRE_W-1:0]   n_retired;
    logic [DATA_W-1:0]     n_wr_cnt;

    logic             all_done;
    logic             is_data;
    logic [SRC_W-1:0] cand1;
    logic [SRC_W-1:0] cand2;

    function automatic logic [TURN_CNT_W-1:0] turn_len(input logic [SRC_W-1:0] src);
        case (src)
            SRC_A:   turn_len = TURN_CNT_W'(TURN_LENGTH_A);
            SRC_B:   turn_len = TURN_CNT_W'(TURN_LENGTH_B);
            default: turn_len = TURN_CNT_W'(TURN_LENGTH_C);
        endcase
    endfunction

    function automatic logic [SRC_W-1:0] next_src(input logic [SRC_W-1:0] src);
        next_src = (src == SRC_C) ? SRC_A : src + SRC_W'(1);
    endfunction

    // next state for one accepted item
    always_comb begin
        all_done   = (r_retired == '1);
        is_data    = (i_marker == MARKER_DATA) && !all_done;
        cand1      = next_src(r_cur_src);
        cand2      = next_src(cand1);
        n_retired  = r_retired;
        n_turn_cnt = r_turn_cnt + TURN_CNT_W'(1);
        n_cur_src  = r_cur_src;
        n_wr_cnt   = r_wr_cnt + DATA_W'(is_data);
        if (!all_done && (i_marker == MARKER_EOS)) begin
            n_retired[r_cur_src] = 1'b1;
        end
        // end of turn: hop to the next live source, else stay
        if ((n_retired != '1) &&
            ((n_turn_cnt >= turn_len(r_cur_src)) || n_retired[r_cur_src])) begin
            n_turn_cnt = '0;
            if (!n_retired[cand1]) begin
                n_cur_src = cand1;
            end else if (!n_retired[cand2]) begin
                n_cur_src = cand2;
            end
        end
        // finished block ignores further items
        if (all_done) begin
            n_turn_cnt = r_turn_cnt;
            n_cur_src  = r_cur_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_src  <= SRC_A;
            r_turn_cnt <= '0;
            r_retired  <= '0;
            r_wr_cnt   <= '0;
        end else if (i_accept) begin
            r_cur_src  <= n_cur_src;
            r_turn_cnt <= n_turn_cnt;
            r_retired  <= n_retired;
            r_wr_cnt   <= n_wr_cnt;
        end
    end

    assign o_status.write_valid  = is_data;
    assign o_status.next_source  = n_cur_src;
    assign o_status.all_finished = (n_retired == '1);
    assign o_status.all_done     = all_done;
    assign o_wr_cnt              = r_wr_cnt;

endmodule

/* rtl/core/masked_result_drain_arbiter.sv */
// Top level of the masked result drain arbiter: register port, masking lanes,
// scheduler, partition offset and the output register with skid entry. Depends on mrda_pkg.

// One packet per clock while the skid entry is empty. Each packet comes
// from the source named in the previous result and yields exactly one
// result; data packets are written at partition offset plus the running
// write count, with each of the PACKED_LANES lanes masked side by side and
// merged into one result. The output has a result register plus a skid
// entry, so the input stays ready while one result waits downstream. The
// partition offset is worked out during the register write's setup and
// access cycles and is ready for the very next packet.
module masked_result_drain_arbiter
    import mrda_pkg::*;
#(
    parameter int PACKED_LANES      = 4,
    parameter int VALUE_WIDTH       = 32,
    parameter int OUTPUT_BLOCK_ROWS = 8192,
    parameter int TURN_LENGTH_A     = 4,
    parameter int TURN_LENGTH_B     = 6,
    parameter int TURN_LENGTH_C     = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // lane0, lane1, lane2, lane3, mask_lane0, mask_lane1, mask_lane2, mask_lane3
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // marker
    input  logic [1:0]             s_axis_tuser,
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // write_address, out_lane0, out_lane1, out_lane2, out_lane3, next_source,
    // all_finished, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // write_valid
    output logic [0:0]             m_axis_tuser
);

    logic [DATA_W-1:0] r_zero_value;
    t_mask_mode        r_mask_mode;
    logic [PART_W-1:0] r_partition;

    logic              cfg_wr;
    logic              cfg_setup;
    logic [1:0]        cfg_idx;
    logic              s_fire;
    logic              m_fire;

    t_sched_status     sts;
    logic [DATA_W-1:0] wr_cnt;
    logic [DATA_W-1:0] offset;
    logic [NUM_LANES-1:0][DATA_W-1:0] lane_val;
    t_result           n_res;

    t_result           r_out;
    logic              r_out_valid;
    t_result           r_skid;
    logic              r_skid_valid;

    // register port decode
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_setup = psel && !penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_value <= '0;
            r_mask_mode  <= MASK_NONE;
            r_partition  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ZERO_VALUE: r_zero_value <= pwdata;
                REG_MASK_MODE:  r_mask_mode  <= t_mask_mode'(pwdata[1:0]);
                REG_PARTITION:  r_partition  <= pwdata[PART_W-1:0];
                default:        ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_idx)
            REG_ZERO_VALUE: prdata = r_zero_value;
            REG_MASK_MODE:  prdata = APB_DATA_W'(r_mask_mode);
            REG_PARTITION:  prdata = APB_DATA_W'(r_partition);
            default:        prdata = '0;
        endcase
    end

    // partition base offset
    mrda_offset #(
        .PACKED_LANES      (PACKED_LANES),
        .OUTPUT_BLOCK_ROWS (OUTPUT_BLOCK_ROWS)
    ) u_offset (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_setup  (cfg_setup),
        .i_part   (pwdata[PART_W-1:0]),
        .i_commit (cfg_wr && (cfg_idx == REG_PARTITION)),
        .o_offset (offset)
    );

    // turn scheduler
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    mrda_sched #(
        .TURN_LENGTH_A (TURN_LENGTH_A),
        .TURN_LENGTH_B (TURN_LENGTH_B),
        .TURN_LENGTH_C (TURN_LENGTH_C)
    ) u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_fire),
        .i_marker (t_marker'(s_axis_tuser)),
        .o_status (sts),
        .o_wr_cnt (wr_cnt)
    );

    // masking lanes, unused lanes read zero
    generate
        for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
            if (k < PACKED_LANES) begin : g_used
                mrda_lane #(
                    .VALUE_WIDTH (VALUE_WIDTH)
                ) u_lane (
                    .i_value (s_axis_tdata[k*DATA_W +: DATA_W]),
                    .i_mask  (s_axis_tdata[(NUM_LANES+k)*DATA_W +: DATA_W]),
                    .i_zero  (r_zero_value),
                    .i_mode  (r_mask_mode),
                    .o_value (lane_val[k])
                );
            end else begin : g_unused
                assign lane_val[k] = '0;
            end
        end
    endgenerate

    // merge lanes and scheduler into one result
    always_comb begin
        n_res.write_valid  = sts.write_valid;
        n_res.address      = sts.write_valid ? offset + wr_cnt : '0;
        n_res.lanes        = sts.write_valid ? lane_val : '0;
        n_res.next_source  = sts.next_source;
        n_res.all_finished = sts.all_finished;
    end

    // output register with one skid entry
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid  <= r_skid_valid || s_fire;
            r_skid_valid <= 1'b0;
        end else if (s_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (s_fire) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.write_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out.all_finished, r_out.next_source,
                            r_out.lanes, r_out.address};

    // skid entry only holds a result behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // write count moves by one exactly for each accepted data packet
    a_wr_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (wr_cnt == $past(wr_cnt) + DATA_W'($past(sts.write_valid))))
        else $error("write count out of step with written packets");

    // once every source is retired, no further packet moves the write count
    a_done_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && sts.all_done) |=> ($stable(wr_cnt) && sts.all_done))
        else $error("state changed after all sources finished");

    // no result item is dropped while the output stalls
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_out_valid && !m_fire) |=> r_skid_valid)
        else $error("result dropped under output stall");

endmodule
